/* rtl/m5e_pkg.sv */
// ----------------------------------------------------------------------------
// m5e_pkg
// shared constants, controller states and controller/datapath command types
// ----------------------------------------------------------------------------
package m5e_pkg;

  localparam int DEFAULT_WINDOW_SIZE  = 5;
  localparam int DEFAULT_SAMPLE_WIDTH = 16;

  // smoothing weight, q0.16
  localparam int WEIGHT_WIDTH = 16;
  localparam int FRAC_BITS    = 16;
  localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_RESET = 16'd13107;

  // apb register map: word index is paddr[2]
  localparam int PADDR_WIDTH = 3;
  localparam int PDATA_WIDTH = 32;
  localparam logic REG_SMOOTHING_WEIGHT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_MUL,
    ST_ACC
  } ctrl_state_t;

  typedef struct packed {
    logic ready;  // input channel may take a transaction
    logic load;   // write sample into ring, restart candidate scan
    logic rank;   // rank one candidate
    logic mul;    // register weight * difference
    logic emit;   // update average, load output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic last_cand;
    logic out_free;
  } ctrl_status_t;

endpackage

/* rtl/m5e_channels_if.sv */
// ----------------------------------------------------------------------------
// m5e channels
// valid/ready channels for samples and results
// ----------------------------------------------------------------------------
interface m5e_sample_if #(
  parameter int SAMPLE_WIDTH = m5e_pkg::DEFAULT_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface m5e_result_if #(
  parameter int SAMPLE_WIDTH = m5e_pkg::DEFAULT_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] median_value;
  logic signed [SAMPLE_WIDTH-1:0] smoothed_value;

  modport source (output valid, output median_value, output smoothed_value, input ready);
  modport sink   (input valid, input median_value, input smoothed_value, output ready);
endinterface

/* rtl/m5e_ctrl.sv */
// ----------------------------------------------------------------------------
// m5e_ctrl
// sequencer: accept, rank scan, multiply, accumulate and emit
// ----------------------------------------------------------------------------
module m5e_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  m5e_pkg::ctrl_status_t  status,
  output m5e_pkg::ctrl_cmd_t     cmd
);

  m5e_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m5e_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      m5e_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (status.in_valid) begin
          cmd.load   = 1'b1;
          state_next = m5e_pkg::ST_RANK;
        end
      end
      m5e_pkg::ST_RANK: begin
        cmd.rank = 1'b1;
        if (status.last_cand) begin
          state_next = m5e_pkg::ST_MUL;
        end
      end
      m5e_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = m5e_pkg::ST_ACC;
      end
      m5e_pkg::ST_ACC: begin
        // wait for the output register to be free
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = m5e_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = m5e_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/m5e_datapath.sv */
// ----------------------------------------------------------------------------
// m5e_datapath
// sample ring, rank selection of the median, average update, output register
// ----------------------------------------------------------------------------
module m5e_datapath #(
  parameter int WINDOW_SIZE  = m5e_pkg::DEFAULT_WINDOW_SIZE,
  parameter int SAMPLE_WIDTH = m5e_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  m5e_pkg::ctrl_cmd_t                    cmd,
  output m5e_pkg::ctrl_status_t                 status,
  input  logic                                  in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample,
  input  logic [m5e_pkg::WEIGHT_WIDTH-1:0]      weight,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]        median_value,
  output logic signed [SAMPLE_WIDTH-1:0]        smoothed_value
);

  localparam int CW   = $clog2(WINDOW_SIZE);
  localparam int FW   = $clog2(WINDOW_SIZE + 1);
  localparam int FRAC = m5e_pkg::FRAC_BITS;
  localparam int WW   = m5e_pkg::WEIGHT_WIDTH;
  localparam int AW   = SAMPLE_WIDTH + FRAC;
  localparam int PW   = AW + WW + 2;
  localparam logic [CW-1:0] LAST_POS = CW'(WINDOW_SIZE - 1);
  localparam logic [FW-1:0] FULL     = FW'(WINDOW_SIZE);

  logic signed [SAMPLE_WIDTH-1:0] ring [WINDOW_SIZE];
  logic [CW-1:0]                  wp;
  logic [FW-1:0]                  fill;
  logic [CW-1:0]                  cand;
  logic signed [SAMPLE_WIDTH-1:0] median;
  logic signed [PW-1:0]           prod;
  logic signed [AW-1:0]           acc;

  logic signed [SAMPLE_WIDTH-1:0] cand_val;
  logic [WINDOW_SIZE-1:0]         less_vec;
  logic [FW-1:0]                  rank;
  logic signed [AW:0]             diff;
  logic signed [AW-1:0]           acc_next;

  assign cand_val = ring[cand];

  // entry j sorts ahead of the candidate; ties broken by position
  always_comb begin
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      less_vec[j] = (FW'(j) < fill) &&
                    ((ring[j] < cand_val) || ((ring[j] == cand_val) && (CW'(j) < cand)));
    end
  end

  assign rank = FW'($countones(less_vec));

  assign diff     = {median[SAMPLE_WIDTH-1], median, FRAC'(0)} - {acc[AW-1], acc};
  assign acc_next = acc + prod[FRAC+AW-1:FRAC];

  assign status.in_valid  = in_valid;
  assign status.last_cand = ((FW'(cand) + FW'(1)) == fill);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring[wp] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      fill      <= '0;
      cand      <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        wp   <= (wp == LAST_POS) ? '0 : wp + CW'(1);
        fill <= (fill == FULL) ? fill : fill + FW'(1);
        cand <= '0;
      end else if (cmd.rank) begin
        cand <= cand + CW'(1);
      end
      if (cmd.emit) begin
        acc       <= acc_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rank && (rank == (fill >> 1))) begin
      median <= cand_val;
    end
    if (cmd.mul) begin
      prod <= diff * $signed({1'b0, weight});
    end
    if (cmd.emit) begin
      median_value   <= median;
      smoothed_value <= acc_next[AW-1:FRAC];
    end
  end

endmodule

/* rtl/median5_then_ema_smoother_unit.sv */
// ----------------------------------------------------------------------------
// median5_then_ema_smoother_unit
// running median over a small sample ring followed by an exponential average
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   samples   in         valid/ready        sample
//   results   out        valid/ready        median_value, smoothed_value
//   apb       in         psel/penable       smoothing_weight at byte address 0
//
// an item goes through accept, a rank scan over every held sample (the whole
// window once warm), multiply and accumulate; the next sample is taken only
// after the accumulate step of the last one, so the rank scan bounds the rate
// rst is synchronous and active high; ring contents are not cleared
// a waiting result sits in the output register while the next sample is taken;
// only the accumulate step waits on a stalled result channel
//
module median5_then_ema_smoother_unit #(
  parameter int WINDOW_SIZE  = m5e_pkg::DEFAULT_WINDOW_SIZE,
  parameter int SAMPLE_WIDTH = m5e_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  m5e_sample_if.sink                          samples,
  m5e_result_if.source                        results,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [m5e_pkg::PADDR_WIDTH-1:0]     paddr,
  input  logic [m5e_pkg::PDATA_WIDTH-1:0]     pwdata,
  output logic [m5e_pkg::PDATA_WIDTH-1:0]     prdata,
  output logic                                pready
);

  m5e_pkg::ctrl_cmd_t    cmd;
  m5e_pkg::ctrl_status_t status;

  logic [m5e_pkg::WEIGHT_WIDTH-1:0] weight;
  logic                             weight_sel;

  // apb: pready is always high, word select on paddr[2]
  assign pready     = 1'b1;
  assign weight_sel = (paddr[2] == m5e_pkg::REG_SMOOTHING_WEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= m5e_pkg::WEIGHT_RESET;
    end else if (psel && penable && pwrite && pready && weight_sel) begin
      weight <= pwdata[m5e_pkg::WEIGHT_WIDTH-1:0];
    end
  end

  // reads of unmapped words return zero
  assign prdata = weight_sel
                ? {{(m5e_pkg::PDATA_WIDTH - m5e_pkg::WEIGHT_WIDTH){1'b0}}, weight}
                : '0;

  // sequencer
  m5e_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  assign samples.ready = cmd.ready;

  // ring, rank selection, average and output register
  m5e_datapath #(
    .WINDOW_SIZE  (WINDOW_SIZE),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_valid       (samples.valid),
    .sample         (samples.sample),
    .weight         (weight),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .median_value   (results.median_value),
    .smoothed_value (results.smoothed_value)
  );

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks the running median and exponential average of the smoother unit;
// samples go in over a valid/ready channel and the weight register over apb;
// each sample accepted is run through a local copy of the filter, and every
// result is compared field by field, in order, with that copy or a typed row; a short
// table of edge cases comes first, then random phases at several weights
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW           = m5e_pkg::DEFAULT_SAMPLE_WIDTH;
  localparam int WIN          = m5e_pkg::DEFAULT_WINDOW_SIZE;
  localparam int PADDR_WIDTH  = m5e_pkg::PADDR_WIDTH;
  localparam int PDATA_WIDTH  = m5e_pkg::PDATA_WIDTH;
  localparam int WEIGHT_WIDTH = m5e_pkg::WEIGHT_WIDTH;
  localparam int FRAC_BITS    = m5e_pkg::FRAC_BITS;

  // register map: the weight at byte 0, the next word has no register behind it
  localparam logic [PADDR_WIDTH-1:0] WEIGHT_ADDR = {m5e_pkg::REG_SMOOTHING_WEIGHT, 2'b00};
  localparam logic [PADDR_WIDTH-1:0] UNUSED_ADDR = {~m5e_pkg::REG_SMOOTHING_WEIGHT, 2'b00};

  localparam int PHASES         = 7;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int DRAIN_CYCLES   = 30;

  typedef struct packed {
    logic signed [SW-1:0] median;
    logic signed [SW-1:0] smoothed;
  } filter_out_t;

  // one row of the directed table; known marks a result typed in by hand
  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 known;
    logic signed [SW-1:0] median;
    logic signed [SW-1:0] smoothed;
  } directed_row_t;

  localparam int N_DIRECTED = 20;

  // the first three rows keep the sorted middle at zero, so the average stays zero
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{16'h0000, 1'b1, 16'h0000, 16'h0000},   // first sample after reset
    '{16'h8000, 1'b1, 16'h0000, 16'h0000},   // two held: upper middle is taken
    '{16'h7FFF, 1'b1, 16'h0000, 16'h0000},   // three held: both extremes around zero
    '{16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000, 16'h0000},   // ring now full
    '{16'hFFFF, 1'b0, 16'h0000, 16'h0000},   // first overwrite, ring wraps
    '{16'h0001, 1'b0, 16'h0000, 16'h0000},
    '{16'h5555, 1'b0, 16'h0000, 16'h0000},
    '{16'hAAAA, 1'b0, 16'h0000, 16'h0000},
    '{16'h4000, 1'b0, 16'h0000, 16'h0000},
    '{16'hBFFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000, 16'h0000},
    '{16'h7FFF, 1'b0, 16'h0000, 16'h0000},   // majority at the top
    '{16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000, 16'h0000},   // majority at the bottom, negative floor
    '{16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{16'hFFFE, 1'b0, 16'h0000, 16'h0000}
  };

  logic clk;
  logic rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_WIDTH-1:0] paddr;
  logic [PDATA_WIDTH-1:0] pwdata;
  logic [PDATA_WIDTH-1:0] prdata;
  logic                   pready;

  m5e_sample_if #(.SAMPLE_WIDTH(SW)) samples_ch ();
  m5e_result_if #(.SAMPLE_WIDTH(SW)) results_ch ();

  median5_then_ema_smoother_unit #(
    .WINDOW_SIZE (WIN),
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_ch),
    .results(results_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // local copy of the filter state
  logic signed [SW-1:0]           window_ring [WIN];
  int                             ring_wr_pos;
  int                             ring_fill;
  longint                         avg_acc;     // q(sw).16, wide enough to never wrap
  logic        [WEIGHT_WIDTH-1:0] ema_weight;

  filter_out_t pending_filter_out [$];

  int  mismatches;
  int  samples_sent;
  int  results_seen;
  int  weight_settings;
  bit  quiet_tail;     // no idling on either side once set
  logic signed [SW-1:0] prev_sample;

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_failure(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // one step of the filter: ring write, median of what is held, average update
  function automatic filter_out_t predict_median_and_average(
    input logic signed [SW-1:0] s
  );
    logic signed [SW-1:0] sorted [WIN];
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] med;
    longint               diff;
    filter_out_t          r;
    int                   j;

    window_ring[ring_wr_pos] = s;
    ring_wr_pos = (ring_wr_pos == WIN - 1) ? 0 : ring_wr_pos + 1;
    if (ring_fill < WIN) ring_fill++;

    // insertion sort over the entries written so far only
    for (int i = 0; i < ring_fill; i++) begin
      v = window_ring[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    med = sorted[ring_fill / 2];

    // acc += floor(w * (median - acc) / 2^16), arithmetic shift gives the floor
    diff    = (longint'(med) <<< FRAC_BITS) - avg_acc;
    avg_acc = avg_acc + ((longint'(ema_weight) * diff) >>> FRAC_BITS);

    r.median   = med;
    r.smoothed = SW'(avg_acc >>> FRAC_BITS);
    return r;
  endfunction

  // random sample: mostly uniform, with extremes, values near zero and repeats
  // so that the sort sees ties and the average sees both signs often
  function automatic logic signed [SW-1:0] pick_sample();
    logic signed [SW-1:0] s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       s = 16'h8000;
          1:       s = 16'h7FFF;
          2:       s = 16'h0000;
          default: s = 16'hFFFF;
        endcase
      end
      1:       s = SW'(int'($urandom_range(0, 15)) - 8);
      2:       s = prev_sample;
      default: s = SW'($urandom);
    endcase
    prev_sample = s;
    return s;
  endfunction

  // offer one sample; returns at the edge where the transaction is taken
  task automatic push_sample(input logic signed [SW-1:0] s, input logic known,
                             input filter_out_t typed);
    filter_out_t predicted;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      samples_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    samples_ch.valid  <= 1'b1;
    samples_ch.sample <= s;
    do @(posedge clk); while (!samples_ch.ready);
    // accepted: advance the local filter, keep the hand-typed value if given
    predicted = predict_median_and_average(s);
    pending_filter_out.push_back(known ? typed : predicted);
    samples_sent++;
  endtask

  // stop offering and let every outstanding transaction come back
  task automatic drain_results();
    samples_ch.valid <= 1'b0;
    while (pending_filter_out.size() != 0) @(posedge clk);
  endtask

  // apb write: setup cycle, then access until pready; idle cycle after
  task automatic apb_write(input logic [PADDR_WIDTH-1:0] addr,
                           input logic [PDATA_WIDTH-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // only the low weight bits are held; other addresses are ignored
    if (addr == WEIGHT_ADDR) begin
      ema_weight = data[WEIGHT_WIDTH-1:0];
      weight_settings++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stalls in bursts, ready runs of varying length between
  initial begin : result_sink
    int run_len;
    results_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      results_ch.ready <= 1'b1;
      run_len = $urandom_range(1, 40);
      repeat (run_len) @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        results_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    filter_out_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      results_seen++;
      if (pending_filter_out.size() == 0) begin
        flag_failure($sformatf("result with nothing expected: median %0d smoothed %0d",
                               results_ch.median_value, results_ch.smoothed_value));
      end else begin
        want = pending_filter_out.pop_front();
        if (results_ch.median_value !== want.median)
          flag_failure($sformatf("result %0d median: expected %0d, got %0d",
                                 results_seen, want.median, results_ch.median_value));
        if (results_ch.smoothed_value !== want.smoothed)
          flag_failure($sformatf("result %0d smoothed: expected %0d, got %0d",
                                 results_seen, want.smoothed,
                                 results_ch.smoothed_value));
      end
    end
  end

  // main sequence
  initial begin : stimulus
    logic [WEIGHT_WIDTH-1:0] phase_weight;
    filter_out_t             typed;

    // every input known from time zero
    rst               <= 1'b1;
    samples_ch.valid  <= 1'b0;
    samples_ch.sample <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;

    mismatches      = 0;
    samples_sent    = 0;
    results_seen    = 0;
    weight_settings = 1;
    quiet_tail      = 1'b0;
    prev_sample     = '0;
    ring_wr_pos     = 0;
    ring_fill       = 0;
    avg_acc         = 0;
    ema_weight      = m5e_pkg::WEIGHT_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, run at the reset weight
    for (int i = 0; i < N_DIRECTED; i++) begin
      typed.median   = directed_rows[i].median;
      typed.smoothed = directed_rows[i].smoothed;
      push_sample(directed_rows[i].sample, directed_rows[i].known, typed);
    end

    // random phases: zero weight, largest weight, smallest step, half,
    // two random weights, and back to the reset value with no idling
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_weight = '0;
        1:       phase_weight = '1;
        2:       phase_weight = WEIGHT_WIDTH'(1);
        3:       phase_weight = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};
        6:       phase_weight = m5e_pkg::WEIGHT_RESET;
        default: phase_weight = WEIGHT_WIDTH'($urandom_range(0, 65535));
      endcase
      drain_results();
      // upper data bits carry noise, the register keeps only its low bits
      apb_write(WEIGHT_ADDR, {(PDATA_WIDTH - WEIGHT_WIDTH)'($urandom), phase_weight});
      // a write to the empty word must leave the weight alone
      if (p == 1) apb_write(UNUSED_ADDR, PDATA_WIDTH'($urandom));
      if (p == PHASES - 1) quiet_tail = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        push_sample(pick_sample(), 1'b0, typed);
    end

    // wind down: every result back, then a short quiet window for strays
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_filter_out.size() != 0)
      flag_failure($sformatf("%0d results never arrived", pending_filter_out.size()));

    $display("covered %0d samples and %0d results over %0d weight settings",
             samples_sent, results_seen, weight_settings);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
